FILE: rtl/mlfq_pkg.sv
// Package for the multilevel feedback queue scheduler: sizes, codes,
// request structs and the control/status structs between controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package mlfq_pkg;

    // Sizes
    localparam int NPROC      = 8;
    localparam int PID_W      = 3;
    localparam int NBURST     = 32;
    localparam int IDX_W      = 5;
    localparam int LEN_W      = 8;
    localparam int TOT_W      = 6;
    localparam int TIME_W     = 16;
    localparam int LVL_W      = 2;
    localparam int NQ         = 3;
    localparam int QF_W       = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int PCNT_W     = 4;
    localparam int MEM_DEPTH  = NPROC * NBURST;
    localparam int MEM_AW     = PID_W + IDX_W;

    // Request commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROCESS_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_ONE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM_TWO   = 2'd2;

    // Configuration reset values
    localparam logic [PCNT_W-1:0] RST_PROCESS_COUNT = 4'd8;
    localparam logic [LEN_W-1:0]  RST_QUANTUM_ONE   = 8'd6;
    localparam logic [LEN_W-1:0]  RST_QUANTUM_TWO   = 8'd12;

    // Priority levels
    localparam logic [LVL_W-1:0] LVL_ONE   = 2'd1;
    localparam logic [LVL_W-1:0] LVL_TWO   = 2'd2;
    localparam logic [LVL_W-1:0] LVL_THREE = 2'd3;

    // Outcome of one decision pass
    localparam logic [1:0] DEC_CONT  = 2'd0;
    localparam logic [1:0] DEC_TICK  = 2'd1;
    localparam logic [1:0] DEC_BREAK = 2'd2;

    typedef logic [PID_W-1:0] t_pid;

    typedef struct packed {
        logic             cmd;
        logic [PID_W-1:0] proc_id;
        logic [IDX_W-1:0] burst_index;
        logic [LEN_W-1:0] burst_length;
        logic             last_burst;
    } t_in_req;

    typedef struct packed {
        logic [PID_W-1:0]  running_pid;
        logic              cpu_idle;
        logic              finished_valid;
        logic [PID_W-1:0]  finished_pid;
        logic [TIME_W-1:0] turnaround;
        logic [TIME_W-1:0] wait_time;
        logic [TIME_W-1:0] response_time;
        logic              all_done;
        logic [TIME_W-1:0] clock_now;
        logic [TIME_W-1:0] idle_ticks;
    } t_out_req;

    typedef struct packed {
        logic load;
        logic start;
        logic dec_exec;
        logic io_exec;
        logic rd_sel_io;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] dec_res;
        logic       io_empty;
        logic       io_last;
    } t_dp_stat;

endpackage

FILE: rtl/mlfq_cpu_scheduler_unit.sv
// Multilevel feedback queue CPU scheduler, top level.
// Depends on mlfq_pkg, mlfq_ctrl and mlfq_dp.
//
// Usage:
//   Input channel (i_valid / o_stall / i_req): a load request stores one burst
//   length of one process; a tick request advances the scheduler by one time
//   unit. Output channel (o_valid / i_stall / o_rsp): one result per tick,
//   none per load.
//   Configuration (i_cfg_we / i_cfg_idx / i_cfg_data): process count and the
//   two quanta, written while the block is idle.
// Sequence:
//   A load is stored in the idle state and the next request is taken in the next
//   cycle. A tick runs a start step, then decision passes (a burst store read,
//   then one decision) until a time unit is used or nothing is left; after a used
//   time unit, a read and an update step per process in I/O, both for the single
//   store read port; then the result is loaded once the output register frees.
// Reset (i_rst_n, synchronous, low): queues and I/O list empty, counters zero,
//   configuration at 8 processes and quanta 6 and 12. The burst store has no
//   clear; load every burst before the first tick.
// Stall: a result waits in the output register; the next request is taken
//   meanwhile, and a following tick holds its result until the register frees.
`timescale 1ns / 1ps

module mlfq_cpu_scheduler_unit
    import mlfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  t_in_req               i_req,
    output logic                  o_valid,
    input  logic                  i_stall,
    output t_out_req              o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    mlfq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_cmd_bit(i_req.cmd),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_cmd    (dp_cmd),
        .i_stat   (dp_stat)
    );

    mlfq_dp u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (dp_cmd),
        .o_stat    (dp_stat),
        .i_req     (i_req),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .o_rsp     (o_rsp)
    );

endmodule

FILE: rtl/mlfq_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/mlfq_dp.sv
// Scheduler datapath: process tables, ready queues, I/O list, counters,
// burst store and result register. Depends on mlfq_pkg and mlfq_ram.
`timescale 1ns / 1ps

module mlfq_dp
    import mlfq_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat,
    input  t_in_req               i_req,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_out_req              o_rsp
);

    function automatic logic [1:0] lvl_q(input logic [LVL_W-1:0] l);
        return (l == 2'd0) ? 2'd0 : 2'(l - 2'd1);
    endfunction

    function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    // Configuration
    logic [PCNT_W-1:0] r_cfg_n;
    logic [LEN_W-1:0]  r_q1, r_q2;

    // Per process tables
    logic [TOT_W-1:0]  r_total [NPROC], n_total [NPROC];
    logic [LEN_W-1:0]  r_first [NPROC], n_first [NPROC];
    logic [IDX_W-1:0]  r_pos   [NPROC], n_pos   [NPROC];
    logic [LEN_W-1:0]  r_rem   [NPROC], n_rem   [NPROC];
    logic [LVL_W-1:0]  r_lvl   [NPROC], n_lvl   [NPROC];
    logic [TIME_W-1:0] r_wait  [NPROC], n_wait  [NPROC];
    logic [TIME_W-1:0] r_frt   [NPROC], n_frt   [NPROC];

    // Ready queues and I/O list
    t_pid             r_rq  [NQ][NPROC], n_rq [NQ][NPROC];
    logic [QF_W-1:0]  r_rqf [NQ], n_rqf [NQ];
    t_pid             r_io  [NPROC], n_io [NPROC];
    logic [QF_W-1:0]  r_iof, n_iof, r_io_rd, n_io_rd, r_io_wr, n_io_wr;

    // Scheduler state
    t_pid              r_cur, n_cur;
    logic              r_idle, n_idle;
    logic [LEN_W-1:0]  r_qu, n_qu;
    logic [TIME_W-1:0] r_clk, n_clk, r_idlec, n_idlec;
    logic              r_started, n_started;

    // Per tick report
    logic              r_ran, n_ran;
    t_pid              r_run_pid, n_run_pid;
    logic              r_fin, n_fin;
    t_pid              r_fin_pid, n_fin_pid;
    logic [TIME_W-1:0] r_fin_turn, n_fin_turn, r_fin_wait, n_fin_wait;
    logic [TIME_W-1:0] r_fin_resp, n_fin_resp;
    t_out_req          r_out, n_out;

    logic [NPROC-1:0]  queued;
    logic              all_empty;
    t_pid              io_p;
    t_pid              rd_pid;
    logic [MEM_AW-1:0] raddr;
    logic [LEN_W-1:0]  rdata;

    assign all_empty = (r_rqf[0] == '0) && (r_rqf[1] == '0) && (r_rqf[2] == '0) &&
                       (r_iof == '0) && r_idle;
    assign io_p      = r_io[r_io_rd[PID_W-1:0]];

    // Burst store: read the next burst of the current or the I/O process
    assign rd_pid = i_cmd.rd_sel_io ? io_p : r_cur;
    assign raddr  = {rd_pid, IDX_W'(r_pos[rd_pid] + 1'b1)};

    mlfq_ram #(
        .WIDTH(LEN_W),
        .DEPTH(MEM_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (i_cmd.load),
        .i_waddr({i_req.proc_id, i_req.burst_index}),
        .i_wdata(i_req.burst_length),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // Processes currently held in any ready queue
    always_comb begin
        queued = '0;
        for (int q = 0; q < NQ; q++) begin
            for (int j = 0; j < NPROC; j++) begin
                if (QF_W'(j) < r_rqf[q]) begin
                    queued[r_rq[q][j]] = 1'b1;
                end
            end
        end
    end

    // Status to the controller
    always_comb begin
        o_stat          = '0;
        o_stat.io_empty = (r_iof == '0);
        o_stat.io_last  = (QF_W'(r_io_rd + 1'b1) == r_iof);
        if (all_empty) begin
            o_stat.dec_res = DEC_BREAK;
        end else if (!r_idle && r_rem[r_cur] == '0) begin
            o_stat.dec_res = DEC_CONT;
        end else if (!r_idle && r_lvl[r_cur] >= LVL_TWO && r_rqf[0] != '0) begin
            o_stat.dec_res = DEC_CONT;
        end else if (!r_idle && r_lvl[r_cur] == LVL_THREE && r_rqf[1] != '0) begin
            o_stat.dec_res = DEC_CONT;
        end else if (r_idle) begin
            o_stat.dec_res = (r_rqf[0] != '0 || r_rqf[1] != '0 || r_rqf[2] != '0) ?
                             DEC_CONT : DEC_TICK;
        end else if (r_lvl[r_cur] == LVL_ONE && r_qu == r_q1) begin
            o_stat.dec_res = DEC_CONT;
        end else if (r_lvl[r_cur] == LVL_TWO && r_qu == r_q2) begin
            o_stat.dec_res = DEC_CONT;
        end else begin
            o_stat.dec_res = DEC_TICK;
        end
    end

    // Next state
    always_comb begin : p_next
        logic             push_en;
        logic [1:0]       push_q;
        t_pid             push_p;
        logic             disp_en;
        logic [1:0]       disp_from;
        logic             disp_hit;
        logic [1:0]       disp_q;
        t_pid             tmp [NQ][NPROC];
        logic [QF_W-1:0]  tf [NQ];
        logic [LEN_W-1:0] rem_d;
        logic [PCNT_W-1:0] cnt;
        logic [LEN_W-1:0] qu_t;

        n_total = r_total; n_first = r_first; n_pos = r_pos; n_rem = r_rem;
        n_lvl = r_lvl; n_wait = r_wait; n_frt = r_frt;
        n_rq = r_rq; n_rqf = r_rqf; n_io = r_io; n_iof = r_iof;
        n_io_rd = r_io_rd; n_io_wr = r_io_wr;
        n_cur = r_cur; n_idle = r_idle; n_qu = r_qu; n_clk = r_clk;
        n_idlec = r_idlec; n_started = r_started;
        n_ran = r_ran; n_run_pid = r_run_pid; n_fin = r_fin; n_fin_pid = r_fin_pid;
        n_fin_turn = r_fin_turn; n_fin_wait = r_fin_wait; n_fin_resp = r_fin_resp;
        n_out = r_out;
        push_en = 1'b0; push_q = 2'd0; push_p = '0;
        disp_en = 1'b0; disp_from = 2'd0;
        rem_d = '0; qu_t = '0;
        cnt = r_cfg_n;
        if (r_cfg_n == '0) cnt = PCNT_W'(1);
        else if (r_cfg_n > PCNT_W'(NPROC)) cnt = PCNT_W'(NPROC);

        // Burst load
        if (i_cmd.load) begin
            if (i_req.last_burst) begin
                n_total[i_req.proc_id] = TOT_W'(i_req.burst_index) + 1'b1;
            end
            if (i_req.burst_index == '0) begin
                n_first[i_req.proc_id] = i_req.burst_length;
            end
        end

        // Start of a tick; the first one also starts the run
        if (i_cmd.start) begin
            n_ran = 1'b0; n_run_pid = '0; n_fin = 1'b0; n_fin_pid = '0;
            n_fin_turn = '0; n_fin_wait = '0; n_fin_resp = '0;
            if (!r_started) begin
                for (int i = 0; i < NPROC; i++) begin
                    if (PCNT_W'(i) < cnt) begin
                        n_pos[i] = '0; n_rem[i] = r_first[i]; n_lvl[i] = LVL_ONE;
                        n_wait[i] = '0; n_frt[i] = '0;
                    end
                end
                for (int j = 0; j < NPROC - 1; j++) begin
                    n_rq[0][j] = PID_W'(j + 1);
                end
                n_rqf[0]  = QF_W'(cnt - 1'b1);
                n_cur     = '0; n_idle = 1'b0; n_qu = '0;
                n_started = 1'b1;
            end
        end

        // One decision pass
        if (i_cmd.dec_exec) begin
            n_io_rd = '0;
            n_io_wr = '0;
            if (all_empty) begin
                // nothing left to run
            end else if (!r_idle && r_rem[r_cur] == '0) begin
                // burst ended: finish or go to I/O
                n_qu = '0;
                if (TOT_W'(r_pos[r_cur]) + 1'b1 >= r_total[r_cur]) begin
                    n_fin = 1'b1; n_fin_pid = r_cur; n_fin_turn = r_clk;
                    n_fin_wait = r_wait[r_cur]; n_fin_resp = r_frt[r_cur];
                end else begin
                    n_pos[r_cur] = r_pos[r_cur] + 1'b1;
                    n_rem[r_cur] = rdata;
                    n_io[r_iof[PID_W-1:0]] = r_cur;
                    n_iof = r_iof + 1'b1;
                end
                disp_en = 1'b1;
            end else if (!r_idle && r_lvl[r_cur] >= LVL_TWO && r_rqf[0] != '0) begin
                // preempted by level one
                n_qu = '0;
                push_en = 1'b1; push_q = lvl_q(r_lvl[r_cur]); push_p = r_cur;
                disp_en = 1'b1;
            end else if (!r_idle && r_lvl[r_cur] == LVL_THREE && r_rqf[1] != '0) begin
                // preempted by level two
                n_qu = '0;
                push_en = 1'b1; push_q = 2'd2; push_p = r_cur;
                disp_en = 1'b1; disp_from = 2'd1;
            end else if (r_idle && (r_rqf[0] != '0 || r_rqf[1] != '0 || r_rqf[2] != '0)) begin
                disp_en = 1'b1;
            end else if (!r_idle && r_lvl[r_cur] == LVL_ONE && r_qu == r_q1) begin
                if (r_frt[r_cur] == '0 && r_clk != '0 && r_cur != '0) n_frt[r_cur] = r_clk;
                n_qu = '0; n_lvl[r_cur] = LVL_TWO;
                push_en = 1'b1; push_q = 2'd1; push_p = r_cur;
                disp_en = 1'b1;
            end else if (!r_idle && r_lvl[r_cur] == LVL_TWO && r_qu == r_q2) begin
                if (r_frt[r_cur] == '0 && r_clk != '0 && r_cur != '0) n_frt[r_cur] = r_clk;
                n_qu = '0; n_lvl[r_cur] = LVL_THREE;
                push_en = 1'b1; push_q = 2'd2; push_p = r_cur;
                disp_en = 1'b1; disp_from = 2'd1;
            end else begin
                // one time unit is used
                if (r_idle) begin
                    n_idlec = sat_inc(r_idlec);
                end else begin
                    if (r_frt[r_cur] == '0 && r_clk != '0 && r_cur != '0) n_frt[r_cur] = r_clk;
                    n_rem[r_cur] = r_rem[r_cur] - 1'b1;
                    n_ran = 1'b1; n_run_pid = r_cur;
                end
                for (int i = 0; i < NPROC; i++) begin
                    if (queued[i]) n_wait[i] = sat_inc(r_wait[i]);
                end
                n_clk = sat_inc(r_clk);
                qu_t  = (r_qu == '1) ? r_qu : r_qu + 1'b1;
                n_qu  = (r_idle || r_lvl[r_cur] == LVL_THREE) ? '0 : qu_t;
            end
        end

        // One I/O list entry: count down, requeue in list order when done
        if (i_cmd.io_exec) begin
            rem_d = (r_rem[io_p] != '0) ? r_rem[io_p] - 1'b1 : r_rem[io_p];
            n_rem[io_p] = rem_d;
            n_io_rd = r_io_rd + 1'b1;
            if (rem_d == '0) begin
                if (TOT_W'(r_pos[io_p]) + 1'b1 < r_total[io_p]) begin
                    n_pos[io_p] = r_pos[io_p] + 1'b1;
                    n_rem[io_p] = rdata;
                end
                push_en = 1'b1; push_q = lvl_q(r_lvl[io_p]); push_p = io_p;
                if (o_stat.io_last) n_iof = r_io_wr;
            end else begin
                n_io[r_io_wr[PID_W-1:0]] = io_p;
                n_io_wr = r_io_wr + 1'b1;
                if (o_stat.io_last) n_iof = r_io_wr + 1'b1;
            end
        end

        // Queue update: push first, then dispatch from the highest priority nonempty queue
        for (int q = 0; q < NQ; q++) begin
            tmp[q] = n_rq[q];
            tf[q]  = n_rqf[q];
            if (push_en && push_q == 2'(q)) begin
                tmp[q][tf[q][PID_W-1:0]] = push_p;
                tf[q] = tf[q] + 1'b1;
            end
        end
        disp_hit = 1'b0;
        disp_q   = 2'd0;
        for (int q = NQ - 1; q >= 0; q--) begin
            if (2'(q) >= disp_from && tf[q] != '0) begin
                disp_hit = 1'b1;
                disp_q   = 2'(q);
            end
        end
        if (disp_en) begin
            if (disp_hit) begin
                n_cur  = tmp[disp_q][0];
                n_idle = 1'b0;
                for (int j = 0; j < NPROC - 1; j++) begin
                    tmp[disp_q][j] = tmp[disp_q][j + 1];
                end
                tf[disp_q] = tf[disp_q] - 1'b1;
            end else begin
                n_cur  = '0;
                n_idle = 1'b1;
            end
        end
        n_rq  = tmp;
        n_rqf = tf;

        // Result register
        if (i_cmd.out_load) begin
            n_out.running_pid    = r_run_pid;
            n_out.cpu_idle       = !r_ran;
            n_out.finished_valid = r_fin;
            n_out.finished_pid   = r_fin_pid;
            n_out.turnaround     = r_fin_turn;
            n_out.wait_time      = r_fin_wait;
            n_out.response_time  = r_fin_resp;
            n_out.all_done       = all_empty;
            n_out.clock_now      = r_clk;
            n_out.idle_ticks     = r_idlec;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n   <= RST_PROCESS_COUNT;
            r_q1      <= RST_QUANTUM_ONE;
            r_q2      <= RST_QUANTUM_TWO;
            for (int i = 0; i < NPROC; i++) begin
                r_pos[i]  <= '0;
                r_rem[i]  <= '0;
                r_lvl[i]  <= LVL_ONE;
                r_wait[i] <= '0;
                r_frt[i]  <= '0;
            end
            for (int q = 0; q < NQ; q++) begin
                r_rqf[q] <= '0;
            end
            r_iof     <= '0;
            r_io_rd   <= '0;
            r_io_wr   <= '0;
            r_cur     <= '0;
            r_idle    <= 1'b0;
            r_qu      <= '0;
            r_clk     <= '0;
            r_idlec   <= '0;
            r_started <= 1'b0;
            r_ran     <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_PROCESS_COUNT: r_cfg_n <= i_cfg_data[PCNT_W-1:0];
                    CFG_QUANTUM_ONE:   r_q1    <= i_cfg_data;
                    CFG_QUANTUM_TWO:   r_q2    <= i_cfg_data;
                    default: ;
                endcase
            end
            r_pos     <= n_pos;
            r_rem     <= n_rem;
            r_lvl     <= n_lvl;
            r_wait    <= n_wait;
            r_frt     <= n_frt;
            r_rqf     <= n_rqf;
            r_iof     <= n_iof;
            r_io_rd   <= n_io_rd;
            r_io_wr   <= n_io_wr;
            r_cur     <= n_cur;
            r_idle    <= n_idle;
            r_qu      <= n_qu;
            r_clk     <= n_clk;
            r_idlec   <= n_idlec;
            r_started <= n_started;
            r_ran     <= n_ran;
            r_fin     <= n_fin;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_total    <= n_total;
        r_first    <= n_first;
        r_rq       <= n_rq;
        r_io       <= n_io;
        r_run_pid  <= n_run_pid;
        r_fin_pid  <= n_fin_pid;
        r_fin_turn <= n_fin_turn;
        r_fin_wait <= n_fin_wait;
        r_fin_resp <= n_fin_resp;
        r_out      <= n_out;
    end

    assign o_rsp = r_out;

endmodule

FILE: rtl/mlfq_ctrl.sv
// Scheduler controller: request handshake, decision and I/O sequencing,
// result valid. Depends on mlfq_pkg.
`timescale 1ns / 1ps

module mlfq_ctrl
    import mlfq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  logic     i_cmd_bit,
    output logic     o_stall,
    output logic     o_valid,
    input  logic     i_stall,
    output t_dp_cmd  o_cmd,
    input  t_dp_stat i_stat
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_START    = 3'd1;
    localparam logic [2:0] S_DEC_ADDR = 3'd2;
    localparam logic [2:0] S_DEC_EXEC = 3'd3;
    localparam logic [2:0] S_IO_ADDR  = 3'd4;
    localparam logic [2:0] S_IO_EXEC  = 3'd5;
    localparam logic [2:0] S_RESULT   = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_valid, n_valid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    // Sequencing
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_cmd_bit == CMD_LOAD) o_cmd.load = 1'b1;
                    else n_state = S_START;
                end
            end
            S_START: begin
                o_cmd.start = 1'b1;
                n_state     = S_DEC_ADDR;
            end
            S_DEC_ADDR: begin
                n_state = S_DEC_EXEC;
            end
            S_DEC_EXEC: begin
                o_cmd.dec_exec = 1'b1;
                unique case (i_stat.dec_res)
                    DEC_CONT:  n_state = S_DEC_ADDR;
                    DEC_TICK:  n_state = i_stat.io_empty ? S_RESULT : S_IO_ADDR;
                    default:   n_state = S_RESULT;
                endcase
            end
            S_IO_ADDR: begin
                o_cmd.rd_sel_io = 1'b1;
                n_state         = S_IO_EXEC;
            end
            S_IO_EXEC: begin
                o_cmd.rd_sel_io = 1'b1;
                o_cmd.io_exec   = 1'b1;
                n_state         = i_stat.io_last ? S_RESULT : S_IO_ADDR;
            end
            S_RESULT: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Result valid
    always_comb begin
        n_valid = r_valid;
        if (r_valid && !i_stall) n_valid = 1'b0;
        if (o_cmd.out_load) n_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

FILE: rtl/mlfq_chk.sv
// Port level checks for the scheduler top level, bound to it.
// Depends on mlfq_pkg and mlfq_cpu_scheduler_unit.
`timescale 1ns / 1ps

module mlfq_chk
    import mlfq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input t_in_req               i_req,
    input logic                  o_valid,
    input logic                  i_stall,
    input t_out_req              o_rsp,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // a tick request occupies the block in the next cycle
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req.cmd == CMD_TICK |=> o_stall)
        else $error("tick request did not start work");

    // a load request never raises a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && i_req.cmd == CMD_LOAD && !o_valid |=> !o_valid)
        else $error("result raised by a load request");

    // an idle tick reports process zero
    a_idle_pid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.cpu_idle |-> o_rsp.running_pid == '0)
        else $error("idle tick with a running process");

    // no completion means empty completion fields
    a_fin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_rsp.finished_valid |->
            o_rsp.finished_pid == '0 && o_rsp.turnaround == '0 && o_rsp.wait_time == '0)
        else $error("completion fields set without a completion");

endmodule

bind mlfq_cpu_scheduler_unit mlfq_chk u_chk (.*);
